// File: rtl/core/url_percent_escape_macros.svh
// Assertion macros shared by the url_percent_escape RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef URL_PERCENT_ESCAPE_MACROS_SVH
`define URL_PERCENT_ESCAPE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("url_percent_escape: assertion failed");
`define UPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("url_percent_escape: assertion failed");
`else
`define UPE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/upe_pkg.sv
// Types, constants and helper functions for the percent escaper.
// No dependencies; used by every module of the block.
package upe_pkg;

   localparam logic CFG_PATH_MODE    = 1'b0;
   localparam logic CFG_BUFFER_CHARS = 1'b1;

   localparam logic [15:0] BUFFER_RESET = 16'd2048;
   localparam logic [15:0] MAX_CHAR     = 16'h00FF;
   localparam logic [16:0] ENTRY_MARGIN = 17'd4;
   localparam logic [7:0]  CHAR_PERCENT = 8'h25;
   localparam logic [7:0]  CHAR_NUL     = 8'h00;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PASS,
      OP_ESCAPE,
      OP_FAIL,
      OP_END_OK,
      OP_END_ERR
   } op_code_type;

   typedef struct packed {
      op_code_type code;
      logic [7:0]  ch_code;
      logic [15:0] length;
   } op_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      hex_digit = (nib < 4'd10) ? (8'h30 + wide) : (8'h57 + wide);
   endfunction

   function automatic logic passes(input logic [7:0] c, input logic path);
      logic ok;
      ok = 1'b0;
      if (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) begin
         ok = 1'b1;
      end else if (path) begin
         ok = c inside {8'h2F, 8'h40, 8'h3A, 8'h3B, 8'h5F, 8'h2D,
                        8'h2B, 8'h3D, 8'h2E, 8'h3F, 8'h26, 8'h23};
      end
      passes = ok;
   endfunction

endpackage

// File: rtl/core/upe_front.sv
// Front end: takes input beats, holds configuration and string state, and turns
// each beat but a character after a failure into one queued operation. Depends on upe_pkg.
`include "url_percent_escape_macros.svh"
module upe_front #(
   parameter int MAX_BUFFER_CHARS = 65535
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_kind,
   input  logic [15:0]      req_ch,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [15:0]      csr_data,
   input  logic             q_full,
   output logic             push,
   output upe_pkg::op_type  push_op
);

   localparam logic [15:0] MaxCap = 16'(MAX_BUFFER_CHARS);

   logic        path_mode_ff, path_mode_in;
   logic [15:0] buffer_chars_ff, buffer_chars_in;
   logic [15:0] count_ff, count_in;
   logic        failed_ff, failed_in;
   logic        accept;
   logic [15:0] cap;
   logic        overflow;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign cap       = (buffer_chars_ff > MaxCap) ? MaxCap : buffer_chars_ff;
   assign overflow  = ({1'b0, count_ff} + upe_pkg::ENTRY_MARGIN) > {1'b0, cap};

   always_comb begin
      path_mode_in    = path_mode_ff;
      buffer_chars_in = buffer_chars_ff;
      if (csr_write) begin
         case (csr_index)
            upe_pkg::CFG_PATH_MODE:    path_mode_in    = csr_data[0];
            upe_pkg::CFG_BUFFER_CHARS: buffer_chars_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in        = count_ff;
      failed_in       = failed_ff;
      push            = 1'b0;
      push_op.code    = upe_pkg::OP_PASS;
      push_op.ch_code = req_ch[7:0];
      push_op.length  = 16'd0;
      if (accept) begin
         if (req_kind) begin
            push      = 1'b1;
            count_in  = 16'd0;
            failed_in = 1'b0;
            if (failed_ff || buffer_chars_ff == 16'd0) begin
               push_op.code = upe_pkg::OP_END_ERR;
            end else begin
               push_op.code   = upe_pkg::OP_END_OK;
               push_op.length = count_ff;
            end
         end else if (!failed_ff) begin
            push = 1'b1;
            if (buffer_chars_ff == 16'd0 || req_ch > upe_pkg::MAX_CHAR || overflow) begin
               push_op.code = upe_pkg::OP_FAIL;
               failed_in    = 1'b1;
            end else if (upe_pkg::passes(req_ch[7:0], path_mode_ff)) begin
               push_op.code = upe_pkg::OP_PASS;
               count_in     = count_ff + 16'd1;
            end else begin
               push_op.code = upe_pkg::OP_ESCAPE;
               count_in     = count_ff + 16'd3;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         path_mode_ff    <= 1'b0;
         buffer_chars_ff <= upe_pkg::BUFFER_RESET;
         count_ff        <= 16'd0;
         failed_ff       <= 1'b0;
      end else begin
         path_mode_ff    <= path_mode_in;
         buffer_chars_ff <= buffer_chars_in;
         count_ff        <= count_in;
         failed_ff       <= failed_in;
      end
   end

   `UPE_ASSERT_NEXT(a_end_clears, clock, reset, accept && req_kind, count_ff == 16'd0 && !failed_ff)
   `UPE_ASSERT_IMPL(a_push_needs_room, clock, reset, push, !q_full)

endmodule

// File: rtl/core/upe_queue.sv
// Short operation queue between the front and back ends.
// Depends on upe_pkg for the operation type and depth.
`include "url_percent_escape_macros.svh"
module upe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  upe_pkg::op_type  push_op,
   input  logic             pop,
   output upe_pkg::op_type  head,
   output logic             head_valid,
   output logic             full
);

   localparam int Depth = upe_pkg::QUEUE_DEPTH;
   localparam int Aw    = upe_pkg::QUEUE_AW;
   localparam int Cw    = upe_pkg::QUEUE_CW;

   upe_pkg::op_type entry_ff [Depth];
   logic [Aw-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Aw-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Cw-1:0]   count_ff, count_in;
   logic            do_pop;

   assign full       = count_ff == Cw'(Depth);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? Aw'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? Aw'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `UPE_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= Cw'(Depth))

endmodule

// File: rtl/core/upe_back.sv
// Back end: expands queued operations into result beats through an
// output register. Depends on upe_pkg for the operation type and hex digits.
`include "url_percent_escape_macros.svh"
module upe_back (
   input  logic             clock,
   input  logic             reset,
   input  upe_pkg::op_type  head,
   input  logic             head_valid,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_is_last,
   output logic             rsp_error,
   output logic [15:0]      rsp_length
);

   typedef enum logic [1:0] {
      PHASE_PERCENT,
      PHASE_HIGH,
      PHASE_LOW
   } phase_type;

   logic        valid_ff, valid_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic        error_ff, error_in;
   logic [15:0] length_ff, length_in;
   logic        load;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in  = valid_ff;
      phase_in  = phase_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      error_in  = error_ff;
      length_in = length_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in  = head_valid;
         char_in   = upe_pkg::CHAR_NUL;
         last_in   = 1'b0;
         error_in  = 1'b0;
         length_in = 16'd0;
         if (head_valid) begin
            case (head.code)
               upe_pkg::OP_PASS: begin
                  char_in = head.ch_code;
                  pop     = 1'b1;
               end
               upe_pkg::OP_ESCAPE: begin
                  case (phase_ff)
                     PHASE_PERCENT: begin
                        char_in  = upe_pkg::CHAR_PERCENT;
                        phase_in = PHASE_HIGH;
                     end
                     PHASE_HIGH: begin
                        char_in  = upe_pkg::hex_digit(head.ch_code[7:4]);
                        phase_in = PHASE_LOW;
                     end
                     default: begin
                        char_in  = upe_pkg::hex_digit(head.ch_code[3:0]);
                        phase_in = PHASE_PERCENT;
                        pop      = 1'b1;
                     end
                  endcase
               end
               upe_pkg::OP_FAIL: begin
                  error_in = 1'b1;
                  pop      = 1'b1;
               end
               upe_pkg::OP_END_OK: begin
                  last_in   = 1'b1;
                  length_in = head.length;
                  pop       = 1'b1;
               end
               default: begin
                  last_in  = 1'b1;
                  error_in = 1'b1;
                  pop      = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PHASE_PERCENT;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
      char_ff   <= char_in;
      last_ff   <= last_in;
      error_ff  <= error_in;
      length_ff <= length_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_is_last  = last_ff;
   assign rsp_error    = error_ff;
   assign rsp_length   = length_ff;

   `UPE_ASSERT_IMPL(a_phase_on_escape, clock, reset, phase_ff != PHASE_PERCENT, head_valid && head.code == upe_pkg::OP_ESCAPE)
   `UPE_ASSERT_IMPL(a_length_only_ok, clock, reset, valid_ff && length_ff != 16'd0, last_ff && !error_ff)

endmodule

// File: rtl/core/url_percent_escape.sv
// Top level of the percent escaper: front end, operation queue, back end.
// Depends on upe_pkg, upe_front, upe_queue and upe_back.
//
// The req channel carries one character (kind 0) or an end-of-string mark
// (kind 1) per beat; the rsp channel carries one output character or report
// per beat. Both use valid and stall; a beat moves when valid is high and
// stall is low. Letters, digits and, in path mode, path punctuation come out
// as they are; other characters as '%' and two lower-case hex digits; an end
// mark closes the string with a NUL carrying the length, or an error beat.
// The front end accepts one beat per cycle while the four-entry queue has
// room; the back end sends one result beat per cycle while the receiver does
// not stall, and an escaped character takes three result beats, other items
// one. The first result of an item passes through a queue entry and then the
// output register before it is presented.
// When the receiver stalls, the output register holds its beat, the queue
// fills and then req_stall rises. Characters after a failure produce no beat.
// Reset is synchronous: it empties the queue and output register, clears the
// string state and sets path_mode to 0 and buffer_chars to 2048. The csr port
// must be written by the user only while the block is idle (not enforced).
module url_percent_escape #(
   parameter int MAX_BUFFER_CHARS = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [15:0] req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_is_last,
   output logic        rsp_error,
   output logic [15:0] rsp_length,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic            push;
   upe_pkg::op_type push_op;
   logic            pop;
   upe_pkg::op_type head;
   logic            head_valid;
   logic            q_full;

   upe_front #(
      .MAX_BUFFER_CHARS(MAX_BUFFER_CHARS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_ch    (req_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .push      (push),
      .push_op   (push_op)
   );

   upe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   upe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_is_last  (rsp_is_last),
      .rsp_error    (rsp_error),
      .rsp_length   (rsp_length)
   );

endmodule

// File: verif/escape_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the percent escaper testbench: predicts the response beats
// of every accepted request beat and checks response beats in order.
// Depends on upe_pkg for register indexes and character constants.
package escape_check_pkg;
   import upe_pkg::*;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        is_last;
      logic        error;
      logic [15:0] length;
   } escape_beat_t;

   class escape_scoreboard;
      bit           path_mode;
      bit [15:0]    buffer_chars;
      bit [15:0]    write_count;
      bit           failed;
      escape_beat_t pending[$];
      int           mismatches;

      function new();
         path_mode = 1'b0;
         buffer_chars = BUFFER_RESET;
         write_count = '0;
         failed = 1'b0;
         mismatches = 0;
      endfunction

      function void set_reg(logic idx, logic [15:0] data);
         case (idx)
            CFG_PATH_MODE: begin
               path_mode = data[0];
            end
            CFG_BUFFER_CHARS: begin
               buffer_chars = data;
            end
         endcase
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      function bit is_plain(logic [7:0] c);
         if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
            return 1'b1;
         end
         if (!path_mode) begin
            return 1'b0;
         end
         case (c)
            "/", "@", ":", ";", "_", "-", "+", "=", ".", "?", "&", "#": begin
               return 1'b1;
            end
            default: begin
               return 1'b0;
            end
         endcase
      endfunction

      function logic [7:0] hex_char(logic [3:0] nib);
         if (nib < 4'd10) begin
            return "0" + {4'h0, nib};
         end
         return "a" + {4'h0, nib} - 8'd10;
      endfunction

      function void push_beat(logic [7:0] c, logic last, logic err, logic [15:0] len);
         escape_beat_t b;
         b.out_char = c;
         b.is_last = last;
         b.error = err;
         b.length = len;
         pending.push_back(b);
      endfunction

      // Returns the number of response beats the request beat causes.
      function int note_item(logic kind, logic [15:0] ch);
         if (kind == KIND_END) begin
            if (failed || buffer_chars == 16'd0) begin
               push_beat(CHAR_NUL, 1'b1, 1'b1, 16'd0);
            end else begin
               push_beat(CHAR_NUL, 1'b1, 1'b0, write_count);
            end
            write_count = '0;
            failed = 1'b0;
            return 1;
         end
         if (failed) begin
            return 0;
         end
         if (buffer_chars == 16'd0 || ch > MAX_CHAR
               || ({1'b0, write_count} + 17'd4) > {1'b0, buffer_chars}) begin
            failed = 1'b1;
            push_beat(CHAR_NUL, 1'b0, 1'b1, 16'd0);
            return 1;
         end
         if (is_plain(ch[7:0])) begin
            push_beat(ch[7:0], 1'b0, 1'b0, 16'd0);
            write_count = write_count + 16'd1;
            return 1;
         end
         push_beat(CHAR_PERCENT, 1'b0, 1'b0, 16'd0);
         push_beat(hex_char(ch[7:4]), 1'b0, 1'b0, 16'd0);
         push_beat(hex_char(ch[3:0]), 1'b0, 1'b0, 16'd0);
         write_count = write_count + 16'd3;
         return 3;
      endfunction

      function void complain(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%s", msg);
         end
      endfunction

      function void check_beat(escape_beat_t got);
         escape_beat_t want;
         if (pending.size() == 0) begin
            complain($sformatf("unexpected beat: char %h last %b error %b length %0d",
                               got.out_char, got.is_last, got.error, got.length));
            return;
         end
         want = pending.pop_front();
         if (got.out_char !== want.out_char || got.is_last !== want.is_last
               || got.error !== want.error || got.length !== want.length) begin
            complain($sformatf({"beat mismatch: expected char %h last %b error %b length %0d,",
                                " got char %h last %b error %b length %0d"},
                               want.out_char, want.is_last, want.error, want.length,
                               got.out_char, got.is_last, got.error, got.length));
         end
      endfunction
   endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench of url_percent_escape: drives request beats and
// register writes, stalls the response side and checks every response beat.
// Depends on upe_pkg and escape_check_pkg.
module tb_top;
   import upe_pkg::*;
   import escape_check_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 440;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_CHAR;
   logic [15:0] req_ch = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_is_last;
   logic        rsp_error;
   logic [15:0] rsp_length;
   logic        csr_write = 1'b0;
   logic        csr_index = CFG_PATH_MODE;
   logic [15:0] csr_data = '0;

   escape_scoreboard sb = new();
   int  burst_left = 0;
   int  result_items = 0;
   int  idle_cycles = 0;
   bit  hold_req = 1'b0;

   url_percent_escape u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_ch       (req_ch),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_is_last  (rsp_is_last),
      .rsp_error    (rsp_error),
      .rsp_length   (rsp_length),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_beat({rsp_out_char, rsp_is_last, rsp_error, rsp_length});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver stalls on a changing pattern, or holds off for a long
   // stretch when the stimulus asks for it.
   initial begin : receiver
      stall_mode_t mode;
      int          mode_left;
      int          hold_left;
      mode = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_t'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            case (mode)
               STALL_NONE: begin
                  rsp_stall = 1'b0;
               end
               STALL_LIGHT: begin
                  rsp_stall = ($urandom_range(0, 3) == 0);
               end
               STALL_HEAVY: begin
                  rsp_stall = ($urandom_range(0, 99) < 70);
               end
               default: begin
                  rsp_stall = ~rsp_stall;
               end
            endcase
         end
      end
   end

   task automatic send_item(input logic kind, input logic [15:0] ch);
      int  gap;
      bit  taken;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid = 1'b1;
      req_kind = kind;
      req_ch = ch;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
      void'(sb.note_item(kind, ch));
      result_items++;
   endtask

   task automatic settle_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] data);
      settle_idle();
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(negedge clock);
      csr_write = 1'b0;
      sb.set_reg(idx, data);
   endtask

   function automatic logic [15:0] pick_char();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         n = $urandom_range(0, 61);
         if (n < 26) begin
            return 16'("a" + n);
         end else if (n < 52) begin
            return 16'("A" + n - 26);
         end
         return 16'("0" + n - 52);
      end else if (r < 55) begin
         case ($urandom_range(0, 11))
            0: return 16'("/");
            1: return 16'("@");
            2: return 16'(":");
            3: return 16'(";");
            4: return 16'("_");
            5: return 16'("-");
            6: return 16'("+");
            7: return 16'("=");
            8: return 16'(".");
            9: return 16'("?");
            10: return 16'("&");
            default: return 16'("#");
         endcase
      end else if (r < 90) begin
         return 16'($urandom_range(0, 255));
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic send_string();
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      repeat (len) send_item(KIND_CHAR, pick_char());
      if ($urandom_range(0, 9) != 0) begin
         send_item(KIND_END, 16'($urandom_range(0, 65535)));
      end
   endtask

   initial begin : stimulus
      int          phase;
      logic [15:0] cap;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Letters and digits, then characters to escape, with the upper path_mode bits set but bit 0 clear.
      write_reg(CFG_PATH_MODE, 16'hFFFE);
      send_item(KIND_CHAR, 16'("a"));
      send_item(KIND_CHAR, 16'("Z"));
      send_item(KIND_CHAR, 16'("0"));
      send_item(KIND_CHAR, 16'("9"));
      send_item(KIND_CHAR, 16'("z"));
      send_item(KIND_CHAR, 16'("A"));
      send_item(KIND_CHAR, 16'("/"));
      send_item(KIND_CHAR, 16'(" "));
      send_item(KIND_CHAR, 16'h00FF);
      send_item(KIND_CHAR, 16'h0000);
      send_item(KIND_END, 16'hFFFF);

      write_reg(CFG_PATH_MODE, 16'hFF01);
      send_item(KIND_CHAR, 16'("/"));
      send_item(KIND_CHAR, 16'("@"));
      send_item(KIND_CHAR, 16'("#"));
      send_item(KIND_CHAR, 16'("~"));
      send_item(KIND_END, 16'h0000);

      // A code above one byte fails the string; later characters are dropped.
      send_item(KIND_CHAR, 16'h0100);
      send_item(KIND_CHAR, 16'("a"));
      send_item(KIND_END, 16'h0000);

      write_reg(CFG_BUFFER_CHARS, 16'd0);
      send_item(KIND_CHAR, 16'("a"));
      send_item(KIND_END, 16'h0000);
      send_item(KIND_END, 16'h0000);

      // The first character fits a four-character buffer, the second does not.
      write_reg(CFG_BUFFER_CHARS, 16'd4);
      send_item(KIND_CHAR, 16'("a"));
      send_item(KIND_CHAR, 16'("b"));
      send_item(KIND_END, 16'h0000);

      result_items = 0;
      phase = 0;
      while (result_items < RANDOM_ITEMS) begin
         case (phase)
            0: cap = 16'hFFFF;
            1: cap = 16'd0;
            2: cap = BUFFER_RESET;
            default: begin
               case ($urandom_range(0, 9))
                  0: cap = 16'($urandom_range(0, 8));
                  1, 2: cap = 16'($urandom_range(9, 60));
                  3: cap = 16'hFFFF;
                  default: cap = 16'($urandom_range(61, 65535));
               endcase
            end
         endcase
         write_reg(CFG_PATH_MODE, (16'($urandom_range(0, 65535)) & 16'hFFFE)
                                  | 16'((phase == 0) ? 1 : $urandom_range(0, 1)));
         write_reg(CFG_BUFFER_CHARS, cap);
         if (phase == 2 || phase == 6) begin
            hold_req = 1'b1;
         end
         repeat ($urandom_range(4, 10)) send_string();
         phase++;
      end

      settle_idle();
      repeat (20) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $display("%0d expected beats never arrived", sb.outstanding());
      end
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
